// ----- hdl/cable_rest_length_slew_limiter_unit_assert.svh -----
// Assertion macros used by the checker file of the rest length slew limiter.
`ifndef CABLE_REST_LENGTH_SLEW_LIMITER_UNIT_ASSERT_SVH
`define CABLE_REST_LENGTH_SLEW_LIMITER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk and switched off while rst_n is low.
`define CRLSL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and switched off while rst_n is low.
`define CRLSL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/crlsl_pkg.sv -----
// Package with the widths, payload types and register codes of the slew limiter.
`default_nettype none
package crlsl_pkg;

  localparam int LENGTH_WIDTH = 32;
  localparam int DT_FRAC_BITS = 24;
  localparam int FRAC_BITS    = 16;
  localparam int ULEN_W       = LENGTH_WIDTH - 1;
  localparam int Q_W          = ULEN_W + FRAC_BITS;
  localparam int PROD_W       = 2 * ULEN_W;
  localparam int DIV_CNT_W    = $clog2(Q_W);
  localparam int CFG_IDX_W    = 3;

  localparam logic [ULEN_W-1:0] ONE_Q16 = ULEN_W'(65536);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET_VELOCITY = 3'd0,
    CFG_MAX_TENSION     = 3'd1,
    CFG_STIFFNESS       = 3'd2,
    CFG_MIN_ACTUAL      = 3'd3,
    CFG_MIN_REST        = 3'd4,
    CFG_INIT_REST       = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic signed [LENGTH_WIDTH-1:0] preferred_length;
    logic [ULEN_W-1:0]              actual_length;
    logic [DT_FRAC_BITS-1:0]        time_step;
  } in_item_t;

  typedef struct packed {
    logic [ULEN_W-1:0] rest_length;
    logic              tension_capped;
    logic              status;
  } out_item_t;

endpackage
`default_nettype wire

// ----- hdl/cable_rest_length_slew_limiter_unit.sv -----
// Top level of the cable rest length slew limiter with tension cap.
//
//   channel  | signals                          | direction
//   ---------+----------------------------------+----------
//   input    | in_valid, in_ready, in_data      | in
//   result   | out_valid, out_ready, out_data   | out
//   config   | cfg_we, cfg_index, cfg_data      | in
//
// One transaction at a time: an item passes the multiply, check, step-size and slew
// states to the done state before the next acceptance, a rejected negative wanted
// length goes straight to the done state, and when the tension cap fires the cap
// quotient comes from a restoring divider that resolves one bit per cycle over 47 bits.
// One shared 31x31 multiplier forms both the tension product and the step size.
// A finished result sits in the output register; the next item is accepted while
// it waits, and only the final write stalls until that register is free.
// Reset is synchronous and loads the configuration registers, the control state and the rest length at once.
`default_nettype none
module cable_rest_length_slew_limiter_unit (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire crlsl_pkg::in_item_t            in_data,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output crlsl_pkg::out_item_t                out_data,
  input  wire logic                           cfg_we,
  input  wire logic [crlsl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [crlsl_pkg::ULEN_W-1:0]   cfg_data
);
  import crlsl_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_MUL_A = 8'b0000_0010,
    ST_CHECK = 8'b0000_0100,
    ST_DIV   = 8'b0000_1000,
    ST_CAP   = 8'b0001_0000,
    ST_MUL_B = 8'b0010_0000,
    ST_SLEW  = 8'b0100_0000,
    ST_DONE  = 8'b1000_0000
  } state_t;

  state_t state_r;

  logic [ULEN_W-1:0] tv_r, mt_r, stiff_r, min_act_r, min_rest_r;
  logic [ULEN_W-1:0] cur_rest_r;

  logic [ULEN_W-1:0]       pref_r, act_r, stretch_r, rem_r, slew_r;
  logic [DT_FRAC_BITS-1:0] dt_r;
  logic [PROD_W-1:0]       prod_r;
  logic [Q_W-1:0]          quo_r;
  logic [DIV_CNT_W-1:0]    cnt_r;
  logic                    capped_r, rej_r;
  logic                    out_valid_r;
  out_item_t               out_data_r;

  logic [ULEN_W-1:0] in_pref_u;
  logic [ULEN_W-1:0] mul_a, mul_b;
  logic [PROD_W-1:0] mul_p;
  logic [Q_W-1:0]    limit;
  logic              over;
  logic [ULEN_W:0]   trial, divisor, trial_sub;
  logic              trial_ge;
  logic [ULEN_W-1:0] step, d_up, d_dn, slew_nxt, fin;
  logic              out_free;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || out_ready;

  assign in_pref_u = in_data.preferred_length[ULEN_W-1:0];

  // The shared multiplier: tension product first, step size later.
  always_comb begin
    if (state_r == ST_MUL_B) begin
      mul_a = tv_r;
      mul_b = ULEN_W'(dt_r);
    end else begin
      mul_a = stretch_r;
      mul_b = stiff_r;
    end
  end
  assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

  assign limit = {mt_r, {FRAC_BITS{1'b0}}};
  // A nonzero product implies a real stretch and a nonzero stiffness.
  assign over  = prod_r > PROD_W'(limit);

  // One restoring division step per cycle.
  assign trial     = {rem_r, quo_r[Q_W-1]};
  assign divisor   = {1'b0, stiff_r};
  assign trial_ge  = trial >= divisor;
  assign trial_sub = trial - divisor;

  assign step = prod_r[ULEN_W+DT_FRAC_BITS-1:DT_FRAC_BITS];
  assign d_up = pref_r - cur_rest_r;
  assign d_dn = cur_rest_r - pref_r;

  always_comb begin
    if (pref_r > cur_rest_r) begin
      slew_nxt = cur_rest_r + ((d_up > step) ? step : d_up);
    end else if (pref_r < cur_rest_r && act_r > min_act_r) begin
      slew_nxt = cur_rest_r - ((d_dn > step) ? step : d_dn);
    end else begin
      slew_nxt = cur_rest_r;
    end
  end

  always_comb begin
    if (rej_r) begin
      fin = cur_rest_r;
    end else if (slew_r < min_rest_r) begin
      fin = min_rest_r;
    end else begin
      fin = slew_r;
    end
  end

  // Configuration registers. Writes to the initial rest length index drop, and
  // reset loads the rest length with the constant ONE_Q16 instead.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tv_r       <= ONE_Q16;
      mt_r       <= '1;
      stiff_r    <= ONE_Q16;
      min_act_r  <= '0;
      min_rest_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_TARGET_VELOCITY: tv_r       <= cfg_data;
        CFG_MAX_TENSION:     mt_r       <= cfg_data;
        CFG_STIFFNESS:       stiff_r    <= cfg_data;
        CFG_MIN_ACTUAL:      min_act_r  <= cfg_data;
        CFG_MIN_REST:        min_rest_r <= cfg_data;
        CFG_INIT_REST:       ;
        default:             ;
      endcase
    end
  end

  // Sequencer and control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      cur_rest_r  <= ONE_Q16;
    end else begin
      if (state_r == ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            state_r <= in_data.preferred_length[LENGTH_WIDTH-1] ? ST_DONE : ST_MUL_A;
          end
        end
        ST_MUL_A: state_r <= ST_CHECK;
        ST_CHECK: state_r <= over ? ST_DIV : ST_MUL_B;
        ST_DIV: begin
          if (cnt_r == DIV_CNT_W'(Q_W - 1)) begin
            state_r <= ST_CAP;
          end
        end
        ST_CAP:   state_r <= ST_MUL_B;
        ST_MUL_B: state_r <= ST_SLEW;
        ST_SLEW:  state_r <= ST_DONE;
        ST_DONE: begin
          if (out_free) begin
            cur_rest_r  <= fin;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        pref_r    <= in_pref_u;
        act_r     <= in_data.actual_length;
        dt_r      <= in_data.time_step;
        rej_r     <= in_data.preferred_length[LENGTH_WIDTH-1];
        capped_r  <= 1'b0;
        stretch_r <= (in_data.actual_length > in_pref_u) ?
                     in_data.actual_length - in_pref_u : '0;
      end
      ST_MUL_A: prod_r <= mul_p;
      ST_CHECK: begin
        rem_r <= '0;
        quo_r <= limit;
        cnt_r <= '0;
      end
      ST_DIV: begin
        rem_r <= trial_ge ? trial_sub[ULEN_W-1:0] : trial[ULEN_W-1:0];
        quo_r <= {quo_r[Q_W-2:0], trial_ge};
        cnt_r <= cnt_r + 1'b1;
      end
      ST_CAP: begin
        pref_r   <= (quo_r < Q_W'(act_r)) ? act_r - quo_r[ULEN_W-1:0] : '0;
        capped_r <= 1'b1;
      end
      ST_MUL_B: prod_r <= mul_p;
      ST_SLEW:  slew_r <= slew_nxt;
      ST_DONE: begin
        if (out_free) begin
          out_data_r.rest_length    <= fin;
          out_data_r.tension_capped <= capped_r;
          out_data_r.status         <= rej_r;
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ----- hdl/crlsl_checker.sv -----
// Port-level checker for the slew limiter, bound to the top level.
`default_nettype none
`include "cable_rest_length_slew_limiter_unit_assert.svh"
module crlsl_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_valid,
  input wire logic                            in_ready,
  input wire crlsl_pkg::in_item_t             in_data,
  input wire logic                            out_valid,
  input wire logic                            out_ready,
  input wire crlsl_pkg::out_item_t            out_data,
  input wire logic                            cfg_we
);
  import crlsl_pkg::*;

  // A rejected item never reports a tension cap.
  `CRLSL_ASSERT_NOW(a_reject_not_capped, out_valid && out_data.status, !out_data.tension_capped, "rejected result flags a tension cap")

  // Items are worked one at a time, so no transaction directly follows another.
  `CRLSL_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "input ready right after a transaction")

  // A stalled result holds.
  `CRLSL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "stalled result changed")

  // A waiting input holds.
  `CRLSL_ASSERT_NEXT(a_in_hold, in_valid && !in_ready, in_valid && $stable(in_data), "waiting input changed")

  // The user must change registers only while the block is idle with no result pending; the block does not enforce it.
  `CRLSL_ASSERT_NOW(a_cfg_idle, cfg_we, in_ready && !out_valid, "register written while busy")

endmodule

bind cable_rest_length_slew_limiter_unit crlsl_checker u_crlsl_checker (.*);
`default_nettype wire
